// ===== sv/mlqs_pkg.sv =====
// shared constants for the multilevel queue scheduler
// no dependencies; imported by mlqs_store, mlqs_ctrl and multilevel_queue_scheduler
package mlqs_pkg;

    localparam int DEF_LEVELS      = 8;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int KIND_W   = 1;
    localparam int ID_W     = 8;
    localparam int LEVEL_W  = 3;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_ENQ = 1'b0;
    localparam logic [KIND_W-1:0] KIND_REQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // memory command from the controller to the id store
    typedef struct packed {
        logic we;
        logic re;
    } mem_cmd_t;

    // result load request from the controller to the output register
    typedef struct packed {
        logic                load;
        logic                use_mem;
        logic [STATUS_W-1:0] status;
    } res_ctl_t;

endpackage

// ===== sv/mlqs_store.sv =====
// id store: one synchronous memory holding every level's fifo, with a registered read port
// depends on mlqs_pkg
module mlqs_store #(
    parameter int LEVELS      = mlqs_pkg::DEF_LEVELS,
    parameter int QUEUE_DEPTH = mlqs_pkg::DEF_QUEUE_DEPTH,
    parameter int ADDR_W      = $clog2(LEVELS * QUEUE_DEPTH)
) (
    input  logic                     clk,
    input  mlqs_pkg::mem_cmd_t       cmd,
    input  logic [ADDR_W-1:0]        addr,
    input  logic [mlqs_pkg::ID_W-1:0] wdata,
    output logic [mlqs_pkg::ID_W-1:0] rdata
);
    import mlqs_pkg::*;

    localparam int DEPTH = LEVELS * QUEUE_DEPTH;

    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mlqs_ctrl.sv =====
// scheduler control: per-level pointers and counts, slot round robin, level search
// depends on mlqs_pkg; drives the mlqs_store memory and the output register
module mlqs_ctrl #(
    parameter int LEVELS      = mlqs_pkg::DEF_LEVELS,
    parameter int QUEUE_DEPTH = mlqs_pkg::DEF_QUEUE_DEPTH,
    parameter int LVL_W       = $clog2(LEVELS),
    parameter int ADDR_W      = $clog2(LEVELS * QUEUE_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [mlqs_pkg::KIND_W-1:0]   kind,
    input  logic [mlqs_pkg::LEVEL_W-1:0]  level,
    output logic                          idle,
    output mlqs_pkg::mem_cmd_t            cmd,
    output logic [ADDR_W-1:0]             addr,
    output mlqs_pkg::res_ctl_t            res,
    output logic [LVL_W-1:0]              res_lvl
);
    import mlqs_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = $clog2(LEVELS + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic [PTR_W-1:0]  head_reg [LEVELS];
    logic [PTR_W-1:0]  head_next [LEVELS];
    logic [PTR_W-1:0]  tail_reg [LEVELS];
    logic [PTR_W-1:0]  tail_next [LEVELS];
    logic [CNT_W-1:0]  fill_reg [LEVELS];
    logic [CNT_W-1:0]  fill_next [LEVELS];
    logic [LVL_W-1:0]  cur_reg, cur_next;
    logic [SLOT_W-1:0] slots_reg, slots_next;
    logic              state_reg, state_next;
    logic [LVL_W-1:0]  pend_lvl_reg, pend_lvl_next;

    logic [LEVELS-1:0] nonempty;
    logic              stale, need_search, hit, grant_ok, lvl_ok, enq_ok;
    logic [LVL_W:0]    idx_w;
    logic [LVL_W-1:0]  hit_lvl, g_lvl, enq_lvl;
    logic [SLOT_W-1:0] g_slots, left_slots;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // circular search for the first non-empty level starting at the current one
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            nonempty[i] = (fill_reg[i] != '0);
        end
        hit     = 1'b0;
        hit_lvl = cur_reg;
        for (int i = 0; i < LEVELS; i++)
        begin
            idx_w = {1'b0, cur_reg} + (LVL_W+1)'(i);
            if (idx_w >= (LVL_W+1)'(LEVELS))
            begin
                idx_w = idx_w - (LVL_W+1)'(LEVELS);
            end
            if (!hit && nonempty[idx_w[LVL_W-1:0]])
            begin
                hit     = 1'b1;
                hit_lvl = idx_w[LVL_W-1:0];
            end
        end
    end

    always_comb
    begin
        stale       = (slots_reg != '0) && !nonempty[cur_reg];
        need_search = (slots_reg == '0) || stale;
        grant_ok    = need_search ? hit : 1'b1;
        g_lvl       = need_search ? hit_lvl : cur_reg;
        g_slots     = need_search ? (SLOT_W'(LEVELS) - SLOT_W'(hit_lvl)) : slots_reg;
        left_slots  = g_slots - SLOT_W'(1);
        enq_lvl     = LVL_W'(level);
        lvl_ok      = (int'(level) < LEVELS);
        enq_ok      = lvl_ok && (fill_reg[enq_lvl] != CNT_W'(QUEUE_DEPTH));
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        cur_next      = cur_reg;
        slots_next    = slots_reg;
        state_next    = state_reg;
        pend_lvl_next = pend_lvl_reg;
        cmd           = '0;
        addr          = ADDR_W'(enq_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_reg[enq_lvl]);
        res           = '0;
        res_lvl       = pend_lvl_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && kind == KIND_ENQ)
                begin
                    res.load = 1'b1;
                    if (enq_ok)
                    begin
                        cmd.we             = 1'b1;
                        tail_next[enq_lvl] = bump(tail_reg[enq_lvl]);
                        fill_next[enq_lvl] = fill_reg[enq_lvl] + CNT_W'(1);
                        res.status         = ST_QUEUED;
                    end
                    else
                    begin
                        res.status = ST_FULL;
                    end
                end
                else if (accept && kind == KIND_REQ)
                begin
                    if (grant_ok)
                    begin
                        cmd.re           = 1'b1;
                        addr             = ADDR_W'(g_lvl) * ADDR_W'(QUEUE_DEPTH)
                                           + ADDR_W'(head_reg[g_lvl]);
                        head_next[g_lvl] = bump(head_reg[g_lvl]);
                        fill_next[g_lvl] = fill_reg[g_lvl] - CNT_W'(1);
                        slots_next       = left_slots;
                        if (left_slots == '0)
                        begin
                            cur_next = (g_lvl == LVL_W'(LEVELS - 1)) ? '0 : g_lvl + LVL_W'(1);
                        end
                        else
                        begin
                            cur_next = g_lvl;
                        end
                        pend_lvl_next = g_lvl;
                        state_next    = S_READ;
                    end
                    else
                    begin
                        slots_next = '0;
                        res.load   = 1'b1;
                        res.status = ST_EMPTY;
                    end
                end
            end
            S_READ:
            begin
                res.load    = 1'b1;
                res.use_mem = 1'b1;
                res.status  = ST_GRANT;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            cur_reg   <= '0;
            slots_reg <= '0;
            state_reg <= S_IDLE;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            cur_reg   <= cur_next;
            slots_reg <= slots_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_lvl_reg <= pend_lvl_next;
    end

    assign idle = (state_reg == S_IDLE);

    a_read_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> $past(accept && kind == KIND_REQ))
        else $error("memory read stage without a request item");

    a_req_grants: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && accept && kind == KIND_REQ && (|nonempty))
        |=> state_reg == S_READ)
        else $error("request with a non-empty fifo did not grant");

    a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slots_reg != '0 |-> (int'(slots_reg) + int'(cur_reg) <= LEVELS))
        else $error("slot count exceeds the weight of the current level");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !cmd.we && !cmd.re)
        else $error("memory access while a grant read is pending");

endmodule

// ===== sv/multilevel_queue_scheduler.sv =====
// multilevel ready queue with slot-weighted round robin between levels
// depends on mlqs_pkg, mlqs_store and mlqs_ctrl
//
// input channel (in_valid/in_ready): kind, proc_id, level. kind 0 appends
// proc_id to the fifo of its level, kind 1 requests the next process.
// output channel (out_valid/out_ready): status, grant_id, grant_level, one
// item per input item, in order.
// an enqueue's result is registered at the accepting edge, and enqueues
// can be taken one per cycle while the receiver keeps up.
// a request that finds every fifo empty is also answered at the accepting edge.
// for a granted request the level search and pointer update run at the
// accepting edge, the id comes out of the single-port id memory in the
// following cycle, and the input is held off during that read, so no new
// item is taken while a granted request is pending.
// input items are taken while the output register is empty or being read,
// so a stalled receiver holds at most one finished item and backs up the input.
// reset clears all fifo pointers and counts, the current level and its slots;
// the id memory itself is not cleared and needs no clearing pass.
module multilevel_queue_scheduler #(
    parameter int LEVELS      = mlqs_pkg::DEF_LEVELS,
    parameter int QUEUE_DEPTH = mlqs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mlqs_pkg::KIND_W-1:0]     kind,
    input  logic [mlqs_pkg::ID_W-1:0]       proc_id,
    input  logic [mlqs_pkg::LEVEL_W-1:0]    level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mlqs_pkg::STATUS_W-1:0]   status,
    output logic [mlqs_pkg::ID_W-1:0]       grant_id,
    output logic [mlqs_pkg::LEVEL_W-1:0]    grant_level
);
    import mlqs_pkg::*;

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);

    logic              idle, accept;
    mem_cmd_t          cmd;
    res_ctl_t          res;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   rdata;
    logic [LVL_W-1:0]  res_lvl;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     grant_id_reg;
    logic [LEVEL_W-1:0]  grant_level_reg;

    assign in_ready = idle && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    mlqs_ctrl #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LVL_W       (LVL_W),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (kind),
        .level   (level),
        .idle    (idle),
        .cmd     (cmd),
        .addr    (addr),
        .res     (res),
        .res_lvl (res_lvl)
    );

    mlqs_store #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .clk   (clk),
        .cmd   (cmd),
        .addr  (addr),
        .wdata (proc_id),
        .rdata (rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            status_reg      <= res.status;
            grant_id_reg    <= res.use_mem ? rdata : '0;
            grant_level_reg <= res.use_mem ? LEVEL_W'(res_lvl) : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign grant_id    = grant_id_reg;
    assign grant_level = grant_level_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> !out_valid_reg || out_ready)
        else $error("result loaded over an item not yet taken");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !accept || $past(kind == KIND_ENQ) || $past(res.load))
        else $error("new item taken while a grant is pending");

    a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_GRANT |-> grant_id_reg == '0)
        else $error("non-grant item carries an id");

endmodule
